// ===== rtl/sph_icg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SPH interface color gradient package
// Shared widths, register indexes, command and status types.
// ----------------------------------------------------------------------------
package sph_icg_pkg;

  localparam int VOL_W     = 31;
  localparam int DENS_W    = 31;
  localparam int DW_W      = 32;
  localparam int DIR_W     = 16;
  localparam int GRAD_W    = 32;
  localparam int NORM_W    = 16;
  localparam int SUM_W     = 48;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 34;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_DENSITY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONTACT_A   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONTACT_B   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONTACT_C   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONTACT_D   = 3'd4;

  localparam logic [DENS_W-1:0] DENS_RESET = 31'd65536000;
  localparam logic [1:0]        COMP_LAST  = 2'd2;

  typedef enum logic [1:0] {
    DK_R,
    DK_Q,
    DK_V,
    DK_N
  } div_kind_t;

  typedef enum logic [2:0] {
    MOP_VI,
    MOP_VJ,
    MOP_QW,
    MOP_MR,
    MOP_ME,
    MOP_GG
  } mul_op_t;

  typedef struct packed {
    logic        load;
    logic        div_start;
    logic        div_take;
    div_kind_t   dkind;
    logic        mul_en;
    mul_op_t     mop;
    logic        macc;
    logic        g_load;
    logic        root_init;
    logic        root_step;
    logic        out_load;
    logic [1:0]  idx;
  } cmd_t;

  typedef struct packed {
    logic contrib;
    logic last;
    logic div_done;
    logic root_last;
    logic out_full;
  } sts_t;

  typedef struct packed {
    logic [VOL_W-1:0]        own_volume;
    logic                    on_surface;
    logic [1:0]              body;
    logic                    neighbour_present;
    logic [VOL_W-1:0]        neighbour_volume;
    logic signed [DW_W-1:0]  kernel_weight;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    logic                    last;
  } item_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic signed [GRAD_W-1:0] grad_z;
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/sph_icg_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Neighbor item channel
// Valid/ready channel carrying one contact neighbor item.
// ----------------------------------------------------------------------------
interface sph_icg_in_if import sph_icg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [VOL_W-1:0]        own_volume;
  logic                    on_surface;
  logic [1:0]              body;
  logic                    neighbour_present;
  logic [VOL_W-1:0]        neighbour_volume;
  logic signed [DW_W-1:0]  kernel_weight;
  logic signed [DIR_W-1:0] dir_x;
  logic signed [DIR_W-1:0] dir_y;
  logic signed [DIR_W-1:0] dir_z;
  logic                    last;

  modport source (output valid, own_volume, on_surface, body, neighbour_present,
                  neighbour_volume, kernel_weight, dir_x, dir_y, dir_z, last,
                  input ready);
  modport sink (input valid, own_volume, on_surface, body, neighbour_present,
                neighbour_volume, kernel_weight, dir_x, dir_y, dir_z, last,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/sph_icg_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Gradient result channel
// Valid/ready channel carrying the gradient and the surface normal.
// ----------------------------------------------------------------------------
interface sph_icg_out_if import sph_icg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [GRAD_W-1:0] grad_x;
  logic signed [GRAD_W-1:0] grad_y;
  logic signed [GRAD_W-1:0] grad_z;
  logic signed [NORM_W-1:0] normal_x;
  logic signed [NORM_W-1:0] normal_y;
  logic signed [NORM_W-1:0] normal_z;

  modport source (output valid, grad_x, grad_y, grad_z, normal_x, normal_y, normal_z,
                  input ready);
  modport sink (input valid, grad_x, grad_y, grad_z, normal_x, normal_y, normal_z,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/sph_icg_cfg_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface sph_icg_cfg_if import sph_icg_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [DENS_W-1:0]    data;

  modport source (output valid, reg_index, data, input ready);
  modport sink (input valid, reg_index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/sph_icg_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned 64 by 34 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sph_icg_div import sph_icg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic [DIV_NUM_W-1:0] quo,
  output logic                 done
);

  logic [6:0]           cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] dvs;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W+1:0] diff;
  logic                 fits;

  assign rem_sh = {rem, quo[DIV_NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs};
  assign fits   = ~diff[DIV_DEN_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= 7'(DIV_NUM_W);
      end else if (cnt != '0) begin
        cnt  <= cnt - 7'd1;
        done <= (cnt == 7'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      dvs <= den;
    end else if (cnt != '0) begin
      rem <= fits ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
      quo <= {quo[DIV_NUM_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sph_icg_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Controller
// Sequences the term and accumulation steps of each contributing item, then the norm and normal steps after the last.
// ----------------------------------------------------------------------------
module sph_icg_ctrl import sph_icg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [19:0] {
    S_IDLE = 20'h00001,
    S_EVAL = 20'h00002,
    S_RGO  = 20'h00004,
    S_RWT  = 20'h00008,
    S_SVI  = 20'h00010,
    S_SVJ  = 20'h00020,
    S_QGO  = 20'h00040,
    S_QWT  = 20'h00080,
    S_MQW  = 20'h00100,
    S_MMR  = 20'h00200,
    S_VGO  = 20'h00400,
    S_VWT  = 20'h00800,
    S_TERM = 20'h01000,
    S_GLD  = 20'h02000,
    S_GSQ  = 20'h04000,
    S_RINI = 20'h08000,
    S_ROOT = 20'h10000,
    S_NGO  = 20'h20000,
    S_NWT  = 20'h40000,
    S_OUT  = 20'h80000
  } state_t;

  state_t     state, state_next;
  logic [1:0] idx, idx_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.idx    = idx;
    state_next = state;
    idx_next   = idx;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.contrib) state_next = S_RGO;
        else if (sts.last) state_next = S_GLD;
        else state_next = S_IDLE;
      end
      S_RGO: begin
        cmd.dkind     = DK_R;
        cmd.div_start = 1'b1;
        state_next    = S_RWT;
      end
      S_RWT: begin
        cmd.dkind = DK_R;
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          state_next   = S_SVI;
        end
      end
      S_SVI: begin
        cmd.mul_en = 1'b1;
        cmd.mop    = MOP_VI;
        state_next = S_SVJ;
      end
      S_SVJ: begin
        cmd.mul_en = 1'b1;
        cmd.mop    = MOP_VJ;
        cmd.macc   = 1'b1;
        state_next = S_QGO;
      end
      S_QGO: begin
        cmd.dkind     = DK_Q;
        cmd.div_start = 1'b1;
        state_next    = S_QWT;
      end
      S_QWT: begin
        cmd.dkind = DK_Q;
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          state_next   = S_MQW;
        end
      end
      S_MQW: begin
        cmd.mul_en = 1'b1;
        cmd.mop    = MOP_QW;
        state_next = S_MMR;
      end
      S_MMR: begin
        cmd.mul_en = 1'b1;
        cmd.mop    = MOP_MR;
        state_next = S_VGO;
      end
      S_VGO: begin
        cmd.dkind     = DK_V;
        cmd.div_start = 1'b1;
        state_next    = S_VWT;
      end
      S_VWT: begin
        cmd.dkind = DK_V;
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          state_next   = S_TERM;
        end
      end
      S_TERM: begin
        cmd.mul_en = 1'b1;
        cmd.mop    = MOP_ME;
        if (idx == COMP_LAST) begin
          idx_next   = '0;
          state_next = sts.last ? S_GLD : S_IDLE;
        end else begin
          idx_next = idx + 2'd1;
        end
      end
      S_GLD: begin
        cmd.g_load = 1'b1;
        state_next = S_GSQ;
      end
      S_GSQ: begin
        cmd.mul_en = 1'b1;
        cmd.mop    = MOP_GG;
        cmd.macc   = (idx != '0);
        if (idx == COMP_LAST) begin
          idx_next   = '0;
          state_next = S_RINI;
        end else begin
          idx_next = idx + 2'd1;
        end
      end
      S_RINI: begin
        cmd.root_init = 1'b1;
        state_next    = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.root_last) state_next = S_NGO;
      end
      S_NGO: begin
        cmd.dkind     = DK_N;
        cmd.div_start = 1'b1;
        state_next    = S_NWT;
      end
      S_NWT: begin
        cmd.dkind = DK_N;
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          if (idx == COMP_LAST) begin
            idx_next   = '0;
            state_next = S_OUT;
          end else begin
            idx_next   = idx + 2'd1;
            state_next = S_NGO;
          end
        end
      end
      S_OUT: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/sph_icg_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Datapath
// Item registers, shared multiplier, divider, square root, sums and output.
// ----------------------------------------------------------------------------
module sph_icg_dp import sph_icg_pkg::*; #(
  parameter int CONTACT_BODIES = 4,
  parameter int DIMENSIONS     = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  item_t                item,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DENS_W-1:0]    cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output res_t                 res
);

  logic [DENS_W-1:0] own;
  logic [DENS_W-1:0] dens [4];

  logic [VOL_W-1:0]        vi, vj;
  logic                    surf, present, last_r;
  logic [1:0]              body;
  logic signed [DW_W-1:0]  dw;
  logic signed [DIR_W-1:0] e [3];

  logic [16:0]              r;
  logic [30:0]              q, m;
  logic [63:0]              acc;
  logic signed [SUM_W-1:0]  sum [3];
  logic signed [GRAD_W-1:0] g [3];
  logic signed [NORM_W-1:0] n [3];
  logic [63:0]              rv, rres, rbit, rtry;

  logic [31:0]              dsum;
  logic [31:0]              aw, ag;
  logic [15:0]              ae;
  logic signed [DIR_W-1:0]  e_sel;
  logic signed [GRAD_W-1:0] g_sel;
  logic signed [SUM_W-1:0]  sum_sel, sum_new;
  logic [31:0]              mul_a, mul_b;
  logic [63:0]              prod;
  logic [31:0]              t;
  logic signed [SUM_W:0]    tmag, tv, s49;
  logic                     term_neg;

  logic [DIV_NUM_W-1:0] div_num, div_quo;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;

  function automatic logic [30:0] sat31(input logic [63:0] v);
    sat31 = (v[63:31] != '0) ? '1 : v[30:0];
  endfunction

  function automatic logic signed [GRAD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    if (v[SUM_W-1:GRAD_W-1] == {(SUM_W-GRAD_W+1){v[SUM_W-1]}}) sat32 = v[GRAD_W-1:0];
    else sat32 = v[SUM_W-1] ? {1'b1, {(GRAD_W-1){1'b0}}} : {1'b0, {(GRAD_W-1){1'b1}}};
  endfunction

  assign dsum    = 32'(own) + 32'(dens[body]);
  assign e_sel   = e[cmd.idx];
  assign g_sel   = g[cmd.idx];
  assign sum_sel = sum[cmd.idx];
  assign aw      = dw[DW_W-1] ? 32'(-dw) : 32'(dw);
  assign ae      = e_sel[DIR_W-1] ? 16'(-e_sel) : 16'(e_sel);
  assign ag      = g_sel[GRAD_W-1] ? 32'(-g_sel) : 32'(g_sel);

  always_comb begin
    case (cmd.mop)
      MOP_VI: begin mul_a = {1'b0, vi}; mul_b = {1'b0, vi}; end
      MOP_VJ: begin mul_a = {1'b0, vj}; mul_b = {1'b0, vj}; end
      MOP_QW: begin mul_a = {1'b0, q};  mul_b = aw; end
      MOP_MR: begin mul_a = {1'b0, m};  mul_b = {15'b0, r}; end
      MOP_ME: begin mul_a = {1'b0, m};  mul_b = {16'b0, ae}; end
      MOP_GG: begin mul_a = ag;         mul_b = ag; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign t        = prod[45:14];
  assign term_neg = dw[DW_W-1] ^ e_sel[DIR_W-1];
  assign tmag     = $signed({17'b0, t});
  assign tv       = term_neg ? -tmag : tmag;
  assign s49      = {sum_sel[SUM_W-1], sum_sel} + tv;

  always_comb begin
    if (s49[SUM_W] != s49[SUM_W-1]) begin
      sum_new = s49[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_new = s49[SUM_W-1:0];
    end
  end

  always_comb begin
    case (cmd.dkind)
      DK_R: begin div_num = 64'({own, 16'b0}); div_den = 34'(dsum); end
      DK_Q: begin div_num = acc;               div_den = 34'(vj); end
      DK_V: begin div_num = 64'({m, 16'b0});   div_den = 34'(vi); end
      DK_N: begin div_num = 64'({ag, 14'b0});  div_den = rres[33:0] + 34'd1; end
      default: begin div_num = '0; div_den = '0; end
    endcase
  end

  sph_icg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .done  (div_done)
  );

  assign sts.contrib   = surf & present & (int'(body) < CONTACT_BODIES);
  assign sts.last      = last_r;
  assign sts.div_done  = div_done;
  assign sts.root_last = rbit[0];
  assign sts.out_full  = out_valid & ~out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      own <= DENS_RESET;
      for (int k = 0; k < 4; k++) dens[k] <= DENS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OWN_DENSITY: own     <= cfg_data;
        REG_CONTACT_A:   dens[0] <= cfg_data;
        REG_CONTACT_B:   dens[1] <= cfg_data;
        REG_CONTACT_C:   dens[2] <= cfg_data;
        REG_CONTACT_D:   dens[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) sum[k] <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.mul_en && cmd.mop == MOP_ME) sum[cmd.idx] <= sum_new;
      if (cmd.g_load) begin
        for (int k = 0; k < 3; k++) sum[k] <= '0;
      end
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vi      <= item.own_volume;
      surf    <= item.on_surface;
      body    <= item.body;
      present <= item.neighbour_present;
      vj      <= item.neighbour_volume;
      dw      <= item.kernel_weight;
      e[0]    <= item.dir_x;
      e[1]    <= item.dir_y;
      e[2]    <= (DIMENSIONS == 3) ? item.dir_z : '0;
      last_r  <= item.last;
    end
    if (cmd.mul_en) begin
      case (cmd.mop)
        MOP_VI, MOP_VJ, MOP_GG: acc <= (cmd.macc ? acc : 64'd0) + prod;
        MOP_QW: m <= sat31({16'b0, prod[63:16]});
        MOP_MR: m <= prod[46:16];
        default: ;
      endcase
    end
    if (cmd.div_take) begin
      case (cmd.dkind)
        DK_R: r <= (dsum == '0) ? 17'd0 : div_quo[16:0];
        DK_Q: q <= sat31(div_quo);
        DK_V: m <= sat31(div_quo);
        DK_N: n[cmd.idx] <= g_sel[GRAD_W-1] ? -$signed(div_quo[15:0])
                                             : $signed(div_quo[15:0]);
        default: ;
      endcase
    end
    if (cmd.g_load) begin
      for (int k = 0; k < 3; k++) g[k] <= sat32(sum[k]);
    end
    if (cmd.root_init) begin
      rv   <= acc;
      rres <= '0;
      rbit <= 64'd1 << 62;
    end else if (cmd.root_step) begin
      if (rv >= rtry) begin
        rv   <= rv - rtry;
        rres <= (rres >> 1) + rbit;
      end else begin
        rres <= rres >> 1;
      end
      rbit <= rbit >> 2;
    end
    if (cmd.out_load) begin
      res.grad_x   <= g[0];
      res.grad_y   <= g[1];
      res.grad_z   <= g[2];
      res.normal_x <= n[0];
      res.normal_y <= n[1];
      res.normal_z <= n[2];
    end
  end

  assign rtry = rres + rbit;

endmodule
`default_nettype wire

// ===== rtl/sph_interface_color_gradient.sv =====
`default_nettype none
// An item that adds nothing and is not last returns the controller to idle.
// A contributing item runs three divisions.
// A last item adds the 32-step square root and three normal divisions;
// one item is in work at a time.
// Synchronous active-high reset clears the sums and the controller and loads
// every density register with 1000.0.
// ----------------------------------------------------------------------------
// SPH interface color gradient
// Accumulates the color gradient over contact neighbors and emits the normal.
// ----------------------------------------------------------------------------
module sph_interface_color_gradient import sph_icg_pkg::*; #(
  parameter int CONTACT_BODIES = 4,
  parameter int DIMENSIONS     = 3
) (
  input  logic          clk,
  input  logic          rst,
  sph_icg_in_if.sink    items,
  sph_icg_out_if.source results,
  sph_icg_cfg_if.sink   cfg
);

  cmd_t  cmd;
  sts_t  sts;
  item_t item;
  res_t  res;
  logic  in_ready;
  logic  out_valid;

  assign cfg.ready   = 1'b1;
  assign items.ready = in_ready;

  assign item.own_volume        = items.own_volume;
  assign item.on_surface        = items.on_surface;
  assign item.body              = items.body;
  assign item.neighbour_present = items.neighbour_present;
  assign item.neighbour_volume  = items.neighbour_volume;
  assign item.kernel_weight     = items.kernel_weight;
  assign item.dir_x             = items.dir_x;
  assign item.dir_y             = items.dir_y;
  assign item.dir_z             = items.dir_z;
  assign item.last              = items.last;

  assign results.valid    = out_valid;
  assign results.grad_x   = res.grad_x;
  assign results.grad_y   = res.grad_y;
  assign results.grad_z   = res.grad_z;
  assign results.normal_x = res.normal_x;
  assign results.normal_y = res.normal_y;
  assign results.normal_z = res.normal_z;

  sph_icg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  sph_icg_dp #(
    .CONTACT_BODIES (CONTACT_BODIES),
    .DIMENSIONS     (DIMENSIONS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .item      (item),
    .cfg_valid (cfg.valid),
    .cfg_index (cfg.reg_index),
    .cfg_data  (cfg.data),
    .out_valid (out_valid),
    .out_ready (results.ready),
    .res       (res)
  );

endmodule
`default_nettype wire

// ===== rtl/sph_icg_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Port checker
// Concurrent checks on the top-level channels, attached by bind.
// ----------------------------------------------------------------------------
module sph_icg_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] grad_x,
  input logic signed [15:0] normal_x
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(grad_x) && $stable(normal_x))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while previous transaction still in work");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while the block was idle");

  a_zero_normal: assert property (@(posedge clk) disable iff (rst)
    out_valid && grad_x == 32'sd0 |-> normal_x == 16'sd0)
    else $error("nonzero normal for a zero gradient component");

endmodule

bind sph_interface_color_gradient sph_icg_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (items.valid),
  .in_ready  (items.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .grad_x    (results.grad_x),
  .normal_x  (results.normal_x)
);
`default_nettype wire
